[hw/rtl/xclv_pkg.sv]
// Shared types, character codes and helpers for the XOR-checked line validator.
// No dependencies; the line core, the result register and the top refer to this package by scope.
`timescale 1ns / 1ps
`default_nettype none

package xclv_pkg;

  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChEq    = 8'h3D;
  localparam logic [7:0] Ch0     = 8'h30;
  localparam logic [7:0] Ch9     = 8'h39;
  localparam logic [7:0] ChA     = 8'h41;
  localparam logic [7:0] ChF     = 8'h46;

  localparam int unsigned LenW   = 10;
  localparam int unsigned CountW = 4;
  localparam int unsigned CfgW   = 10;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StTooLong = 2'd1,
    StBadSum  = 2'd2,
    StNoType  = 2'd3
  } status_e;

  typedef enum logic {
    RegLineLimit  = 1'b0,
    RegFieldLimit = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    status_e             status;
    logic [LenW-1:0]     content_length;
    logic [CountW-1:0]   type_length;
    logic [CountW-1:0]   field_count;
    logic [7:0]          received_checksum;
    logic [7:0]          computed_checksum;
  } verdict_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  // Decode one uppercase hex digit; a bad digit reads as zero.
  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c inside {[Ch0:Ch9]}) begin
      h.val = 4'(c - Ch0);
    end else if (c inside {[ChA:ChF]}) begin
      h.val = 4'(c - ChA) + 4'd10;
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/xclv_byte_if.sv]
// Valid/ready channel that carries one received byte per word.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface xclv_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

[hw/rtl/xclv_verdict_if.sv]
// Valid/ready channel that carries one line verdict per word.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface xclv_verdict_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [9:0] content_length;
  logic [3:0] type_length;
  logic [3:0] field_count;
  logic [7:0] received_checksum;
  logic [7:0] computed_checksum;

  modport source (
    output valid, output status, output content_length, output type_length,
    output field_count, output received_checksum, output computed_checksum,
    input ready
  );
  modport sink (
    input valid, input status, input content_length, input type_length,
    input field_count, input received_checksum, input computed_checksum,
    output ready
  );
endinterface

`default_nettype wire

[hw/rtl/xclv_in_stage.sv]
// Input register: holds one accepted byte until the line core consumes it.
// Depends on xclv_byte_if.
`timescale 1ns / 1ps
`default_nettype none

module xclv_in_stage (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  xclv_byte_if.sink   rx_i,
  input  wire logic   take_i,
  output logic        valid_o,
  output logic [7:0]  byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       load;

  assign rx_i.ready = !valid_q || take_i;
  assign load       = rx_i.valid && rx_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= rx_i.rx_byte;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

`default_nettype wire

[hw/rtl/xclv_line_core.sv]
// Line state and per-byte update: running XOR, tail check, token counts, verdict.
// Depends on xclv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module xclv_line_core #(
  parameter int unsigned LINE_LIMIT_MAX = 1023,
  parameter int unsigned FIELDS_MAX     = 15,
  parameter int unsigned TYPE_LEN_MAX   = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         valid_i,
  input  wire logic [7:0]                   byte_i,
  input  wire logic                         out_free_i,
  input  wire logic [xclv_pkg::CfgW-1:0]    line_limit_i,
  input  wire logic [xclv_pkg::CountW-1:0]  field_limit_i,
  output logic                              take_o,
  output logic                              push_o,
  output xclv_pkg::verdict_t                verdict_o
);

  localparam int unsigned LimW = 12;
  localparam logic [LimW-1:0] LimMax = LimW'(LINE_LIMIT_MAX);
  localparam logic [xclv_pkg::CountW-1:0] FieldMax = xclv_pkg::CountW'(FIELDS_MAX);
  localparam logic [xclv_pkg::CountW-1:0] TokSat   = xclv_pkg::CountW'(TYPE_LEN_MAX - 1);

  logic [xclv_pkg::LenW-1:0]   line_length_q, line_length_d;
  logic                        overflow_q, overflow_d;
  logic [7:0]                  run_xor_q, run_xor_d;
  logic [7:0]                  xor_at_space_q, xor_at_space_d;
  logic                        space_seen_q, space_seen_d;
  logic [1:0]                  tail_count_q, tail_count_d;
  logic                        tail_star_q, tail_star_d;
  logic [7:0]                  tail_value_q, tail_value_d;
  logic                        tail_hex_ok_q, tail_hex_ok_d;
  logic                        tok_open_q, tok_open_d;
  logic [xclv_pkg::CountW-1:0] tok_len_q, tok_len_d;
  logic                        tok_eq_q, tok_eq_d;
  logic                        type_done_q, type_done_d;
  logic [xclv_pkg::CountW-1:0] type_len_q, type_len_d;
  logic [xclv_pkg::CountW-1:0] fields_q, fields_d;

  logic                        is_cr, is_lf, is_sp;
  logic [LimW-1:0]             limit;
  logic                        full;
  logic [xclv_pkg::CountW-1:0] cap;
  logic                        formed;
  logic                        emit;
  xclv_pkg::hex_t              hex;

  assign is_cr = (byte_i == xclv_pkg::ChCr);
  assign is_lf = (byte_i == xclv_pkg::ChLf);
  assign is_sp = (byte_i == xclv_pkg::ChSpace);
  assign hex   = xclv_pkg::hex_decode(byte_i);

  assign limit = ({2'b00, line_limit_i} < LimMax) ? {2'b00, line_limit_i} : LimMax;
  assign full  = ({2'b00, line_length_q} >= limit);
  assign cap   = (field_limit_i < FieldMax) ? field_limit_i : FieldMax;

  assign formed = space_seen_q && tail_star_q && (tail_count_q == 2'd3) && tail_hex_ok_q;
  assign emit   = is_lf && (overflow_q || (line_length_q != '0));

  // A newline needs room in the result register; other bytes always go.
  assign take_o = valid_i && (!is_lf || out_free_i);
  assign push_o = take_o && emit;

  always_comb begin
    verdict_o = '0;
    if (overflow_q) begin
      verdict_o.status = xclv_pkg::StTooLong;
    end else begin
      verdict_o.type_length       = type_len_q;
      verdict_o.field_count       = fields_q;
      verdict_o.computed_checksum = xor_at_space_q;
      if (!formed) begin
        verdict_o.status = xclv_pkg::StBadSum;
      end else begin
        verdict_o.content_length    = line_length_q - xclv_pkg::LenW'(4);
        verdict_o.received_checksum = tail_value_q;
        if (tail_value_q != xor_at_space_q) begin
          verdict_o.status = xclv_pkg::StBadSum;
        end else if (!type_done_q) begin
          verdict_o.status = xclv_pkg::StNoType;
        end else begin
          verdict_o.status = xclv_pkg::StOk;
        end
      end
    end
  end

  always_comb begin
    line_length_d  = line_length_q;
    overflow_d     = overflow_q;
    run_xor_d      = run_xor_q;
    xor_at_space_d = xor_at_space_q;
    space_seen_d   = space_seen_q;
    tail_count_d   = tail_count_q;
    tail_star_d    = tail_star_q;
    tail_value_d   = tail_value_q;
    tail_hex_ok_d  = tail_hex_ok_q;
    tok_open_d     = tok_open_q;
    tok_len_d      = tok_len_q;
    tok_eq_d       = tok_eq_q;
    type_done_d    = type_done_q;
    type_len_d     = type_len_q;
    fields_d       = fields_q;

    if (!take_o || is_cr) begin
      // hold
    end else if (is_lf) begin
      line_length_d  = '0;
      overflow_d     = 1'b0;
      run_xor_d      = '0;
      xor_at_space_d = '0;
      space_seen_d   = 1'b0;
      tail_count_d   = '0;
      tail_star_d    = 1'b0;
      tail_value_d   = '0;
      tail_hex_ok_d  = 1'b1;
      tok_open_d     = 1'b0;
      tok_len_d      = '0;
      tok_eq_d       = 1'b0;
      type_done_d    = 1'b0;
      type_len_d     = '0;
      fields_d       = '0;
    end else if (full) begin
      overflow_d = 1'b1;
    end else begin
      line_length_d = line_length_q + xclv_pkg::LenW'(1);
      if (is_sp) begin
        xor_at_space_d = run_xor_q;
        run_xor_d      = run_xor_q ^ xclv_pkg::ChSpace;
        if (tok_open_q) begin
          if (!type_done_q) begin
            type_done_d = 1'b1;
            type_len_d  = tok_len_q;
          end else if (tok_eq_q && (fields_q < cap)) begin
            fields_d = fields_q + xclv_pkg::CountW'(1);
          end
        end
        tok_open_d    = 1'b0;
        tok_len_d     = '0;
        tok_eq_d      = 1'b0;
        space_seen_d  = 1'b1;
        tail_count_d  = '0;
        tail_star_d   = 1'b0;
        tail_value_d  = '0;
        tail_hex_ok_d = 1'b1;
      end else begin
        run_xor_d  = run_xor_q ^ byte_i;
        tok_open_d = 1'b1;
        if (tok_len_q < TokSat) begin
          tok_len_d = tok_len_q + xclv_pkg::CountW'(1);
        end
        if (byte_i == xclv_pkg::ChEq) begin
          tok_eq_d = 1'b1;
        end
        if (tail_count_q == 2'd0) begin
          tail_star_d = (byte_i == xclv_pkg::ChStar);
        end else if (tail_count_q != 2'd3) begin
          tail_value_d  = {tail_value_q[3:0], hex.val};
          tail_hex_ok_d = tail_hex_ok_q && hex.ok;
        end else begin
          tail_hex_ok_d = 1'b0;
        end
        if (tail_count_q != 2'd3) begin
          tail_count_d = tail_count_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_length_q  <= '0;
      overflow_q     <= 1'b0;
      run_xor_q      <= '0;
      xor_at_space_q <= '0;
      space_seen_q   <= 1'b0;
      tail_count_q   <= '0;
      tail_star_q    <= 1'b0;
      tail_value_q   <= '0;
      tail_hex_ok_q  <= 1'b1;
      tok_open_q     <= 1'b0;
      tok_len_q      <= '0;
      tok_eq_q       <= 1'b0;
      type_done_q    <= 1'b0;
      type_len_q     <= '0;
      fields_q       <= '0;
    end else begin
      line_length_q  <= line_length_d;
      overflow_q     <= overflow_d;
      run_xor_q      <= run_xor_d;
      xor_at_space_q <= xor_at_space_d;
      space_seen_q   <= space_seen_d;
      tail_count_q   <= tail_count_d;
      tail_star_q    <= tail_star_d;
      tail_value_q   <= tail_value_d;
      tail_hex_ok_q  <= tail_hex_ok_d;
      tok_open_q     <= tok_open_d;
      tok_len_q      <= tok_len_d;
      tok_eq_q       <= tok_eq_d;
      type_done_q    <= type_done_d;
      type_len_q     <= type_len_d;
      fields_q       <= fields_d;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/xclv_out_stage.sv]
// Result register: holds one verdict word until the sink takes it.
// Depends on xclv_pkg and xclv_verdict_if.
`timescale 1ns / 1ps
`default_nettype none

module xclv_out_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire xclv_pkg::verdict_t verdict_i,
  output logic                   free_o,
  xclv_verdict_if.source         verdict_o
);

  logic               valid_q, valid_d;
  xclv_pkg::verdict_t data_q;

  assign free_o = !valid_q || verdict_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (push_i) begin
      valid_d = 1'b1;
    end else if (verdict_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      data_q <= verdict_i;
    end
  end

  assign verdict_o.valid             = valid_q;
  assign verdict_o.status            = data_q.status;
  assign verdict_o.content_length    = data_q.content_length;
  assign verdict_o.type_length       = data_q.type_length;
  assign verdict_o.field_count       = data_q.field_count;
  assign verdict_o.received_checksum = data_q.received_checksum;
  assign verdict_o.computed_checksum = data_q.computed_checksum;

endmodule

`default_nettype wire

[hw/rtl/xor_checked_line_validator.sv]
// XOR-checked line validator: one byte per cycle in unless a newline waits, one verdict per non-empty line out.
// A newline passes the input register, then its verdict is registered in the result register.
// Throughput: one byte every cycle while no newline waits; set by the line state, which updates once per byte.
// A newline waits only while the result register holds an untaken verdict.
// Reset (async, active low) clears all line state; line_limit 256, field_limit 8.
// Depends on xclv_pkg, xclv_byte_if, xclv_verdict_if, xclv_in_stage, xclv_line_core, xclv_out_stage.
`timescale 1ns / 1ps
`default_nettype none

module xor_checked_line_validator #(
  parameter int unsigned LINE_LIMIT_MAX = 1023,
  parameter int unsigned FIELDS_MAX     = 15,
  parameter int unsigned TYPE_LEN_MAX   = 16
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  xclv_byte_if.sink                      rx_i,
  xclv_verdict_if.source                 verdict_o,
  input  wire logic                      cfg_we_i,
  input  wire logic                      cfg_index_i,
  input  wire logic [xclv_pkg::CfgW-1:0] cfg_wdata_i
);

  logic [xclv_pkg::CfgW-1:0]   line_limit_q;
  logic [xclv_pkg::CountW-1:0] field_limit_q;

  logic               byte_valid;
  logic [7:0]         byte_data;
  logic               take;
  logic               push;
  logic               out_free;
  xclv_pkg::verdict_t verdict;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_limit_q  <= xclv_pkg::CfgW'(256);
      field_limit_q <= xclv_pkg::CountW'(8);
    end else if (cfg_we_i) begin
      case (xclv_pkg::cfg_reg_e'(cfg_index_i))
        xclv_pkg::RegLineLimit:  line_limit_q  <= cfg_wdata_i;
        xclv_pkg::RegFieldLimit: field_limit_q <= cfg_wdata_i[xclv_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

  xclv_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rx_i    (rx_i),
    .take_i  (take),
    .valid_o (byte_valid),
    .byte_o  (byte_data)
  );

  xclv_line_core #(
    .LINE_LIMIT_MAX (LINE_LIMIT_MAX),
    .FIELDS_MAX     (FIELDS_MAX),
    .TYPE_LEN_MAX   (TYPE_LEN_MAX)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (byte_valid),
    .byte_i        (byte_data),
    .out_free_i    (out_free),
    .line_limit_i  (line_limit_q),
    .field_limit_i (field_limit_q),
    .take_o        (take),
    .push_o        (push),
    .verdict_o     (verdict)
  );

  xclv_out_stage u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .verdict_i (verdict),
    .free_o    (out_free),
    .verdict_o (verdict_o)
  );

endmodule

`default_nettype wire
